### sv/mhpq_pkg.sv
// Package for the max-heap priority queue: sizes, operation and status codes.
// No dependencies.
package mhpq_pkg;
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
endpackage

### sv/max_heap_priority_queue_unit.sv
// Top level of the max-heap priority queue: sequencer, heap RAM, comparator.
// Depends on mhpq_pkg, mhpq_ram, mhpq_cmp.
//
// Usage: present operation and value with start high while busy is low;
// the word is taken at that clock edge. operation 0 inserts value, 1 removes
// the maximum. One result word is given on removed_value, status and count,
// marked by done high for exactly one cycle; the receiver cannot stall it.
// A full-heap insert or empty-heap remove answers in the cycle after acceptance.
// An insert climbs one level per check/compare pair (S_UP_CHK, S_UP_CMP), and
// ends in S_UP_CHK at the root or in S_UP_CMP when it stops below it.
// A remove reads the root and the last entry, then descends one level per step
// sequence (one RAM read port: left child, right child if present, compare/write),
// and ends in S_DN_CHK at a leaf or in S_DN_CMP when a compare stops it.
// busy is high from the cycle after acceptance until done rises (never for
// full-heap inserts or empty-heap removes); done and a new start may share a cycle.
// A new word is taken only while busy is low, so words are handled one at a time.
// Reset clears the element count and the sequencer; heap contents are not
// cleared, only entries below the count are ever read.
module max_heap_priority_queue_unit
    import mhpq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       operation,
    input  logic signed [KEY_W-1:0]    value,
    output logic                       done,
    output logic signed [KEY_W-1:0]    removed_value,
    output logic [STATUS_W-1:0]        status,
    output logic [COUNT_W-1:0]         count
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_RM_ROOT,
        S_RM_LAST,
        S_DN_CHK,
        S_DN_L,
        S_DN_R,
        S_DN_CMP
    } state_t;

    state_t                     state_reg;
    logic [POS_W-1:0]           cnt_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           child_pos_reg;
    logic signed [KEY_W-1:0]    key_reg;
    logic signed [KEY_W-1:0]    child_reg;
    logic signed [KEY_W-1:0]    removed_reg;
    logic [STATUS_W-1:0]        status_reg;
    logic                       done_reg;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [KEY_W-1:0]           ram_wdata;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [KEY_W-1:0]           ram_rdata;
    logic signed [KEY_W-1:0]    cmp_a;
    logic signed [KEY_W-1:0]    cmp_b;
    logic                       cmp_lt;
    logic [POS_W:0]             left_pos;
    logic [POS_W:0]             right_pos;
    logic                       left_out;
    logic                       right_in;

    assign left_pos  = {pos_reg, 1'b0};
    assign right_pos = left_pos + (POS_W+1)'(1);
    assign left_out  = (left_pos > {1'b0, cnt_reg});
    assign right_in  = (right_pos <= {1'b0, cnt_reg});

    mhpq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mhpq_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    always_comb
    begin
        cmp_a = key_reg;
        cmp_b = child_reg;
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = ram_rdata;
                cmp_b = key_reg;
            end
            S_DN_R:
            begin
                cmp_a = child_reg;
                cmp_b = ram_rdata;
            end
            default:
            begin
                cmp_a = key_reg;
                cmp_b = child_reg;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(pos_reg - POS_W'(1));
        ram_wdata = key_reg;
        ram_raddr = '0;
        case (state_reg)
            S_UP_CHK:
            begin
                ram_raddr = ADDR_W'(pos_reg[POS_W-1:1] - (POS_W-1)'(1));
                ram_we    = (pos_reg == POS_W'(1));
            end
            S_UP_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = cmp_lt ? ram_rdata : key_reg;
            end
            S_RM_ROOT:
            begin
                ram_raddr = ADDR_W'(cnt_reg - POS_W'(1));
            end
            S_DN_CHK:
            begin
                ram_raddr = ADDR_W'(left_pos - (POS_W+1)'(1));
                ram_we    = left_out;
            end
            S_DN_L:
            begin
                ram_raddr = ADDR_W'(left_pos);
            end
            S_DN_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = cmp_lt ? child_reg : key_reg;
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
            pos_reg       <= '0;
            child_pos_reg <= '0;
            key_reg       <= '0;
            child_reg     <= '0;
            removed_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        removed_reg <= '0;
                        status_reg  <= ST_OK;
                        key_reg     <= value;
                        if (operation == OP_INSERT)
                        begin
                            if (cnt_reg >= POS_W'(CAPACITY))
                            begin
                                status_reg <= ST_FULL;
                                done_reg   <= 1'b1;
                            end
                            else
                            begin
                                cnt_reg   <= cnt_reg + POS_W'(1);
                                pos_reg   <= cnt_reg + POS_W'(1);
                                state_reg <= S_UP_CHK;
                            end
                        end
                        else
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_reg <= ST_EMPTY;
                                done_reg   <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_RM_ROOT;
                            end
                        end
                    end
                end
                S_UP_CHK:
                begin
                    if (pos_reg == POS_W'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_UP_CMP;
                    end
                end
                S_UP_CMP:
                begin
                    if (cmp_lt)
                    begin
                        pos_reg   <= {1'b0, pos_reg[POS_W-1:1]};
                        state_reg <= S_UP_CHK;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_RM_ROOT:
                begin
                    removed_reg <= ram_rdata;
                    state_reg   <= S_RM_LAST;
                end
                S_RM_LAST:
                begin
                    key_reg   <= ram_rdata;
                    cnt_reg   <= cnt_reg - POS_W'(1);
                    pos_reg   <= POS_W'(1);
                    state_reg <= S_DN_CHK;
                end
                S_DN_CHK:
                begin
                    if (left_out)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DN_L;
                    end
                end
                S_DN_L:
                begin
                    child_reg     <= ram_rdata;
                    child_pos_reg <= POS_W'(left_pos);
                    state_reg     <= right_in ? S_DN_R : S_DN_CMP;
                end
                S_DN_R:
                begin
                    if (cmp_lt)
                    begin
                        child_reg     <= ram_rdata;
                        child_pos_reg <= POS_W'(right_pos);
                    end
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (cmp_lt)
                    begin
                        pos_reg   <= child_pos_reg;
                        state_reg <= S_DN_CHK;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign count         = COUNT_W'(cnt_reg);
endmodule

### sv/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/mhpq_cmp.sv
// Shared signed key comparator used by sift up and sift down.
// Depends on mhpq_pkg.
module mhpq_cmp
    import mhpq_pkg::*;
(
    input  logic signed [KEY_W-1:0] a,
    input  logic signed [KEY_W-1:0] b,
    output logic                    lt
);
    assign lt = (a < b);
endmodule

### bench/testbench.sv
// Self-checking bench for max_heap_priority_queue_unit: directed, random, fill and near-full tests.
// Keeps its own heap model and checks every result word against it.
// Depends on mhpq_pkg and the RTL of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mhpq_pkg::*;

    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic signed [KEY_W-1:0] removed;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_W-1:0]      held;
    } heap_answer_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    operation = OP_INSERT;
    logic signed [KEY_W-1:0] value = '0;
    logic                    busy;
    logic                    done;
    logic signed [KEY_W-1:0] removed_value;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;

    logic signed [KEY_W-1:0] model_heap [1:CAPACITY];
    int unsigned             model_size = 0;
    heap_answer_t            pending_answers [$];

    int mismatches    = 0;
    int inserts_sent  = 0;
    int removes_sent  = 0;
    int empty_removes = 0;
    int full_inserts  = 0;
    int peak_size     = 0;
    bit steady        = 1'b0;

    max_heap_priority_queue_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .value         (value),
        .done          (done),
        .removed_value (removed_value),
        .status        (status),
        .count         (count)
    );

    always #5 clk = ~clk;

    // heap model: sift up on insert, sift down toward larger child (left on tie) on remove
    function automatic heap_answer_t heap_apply(input logic op,
                                                input logic signed [KEY_W-1:0] key);
        heap_answer_t            ans;
        int unsigned             pos;
        int unsigned             kid;
        logic signed [KEY_W-1:0] tmp;
        ans.removed = '0;
        ans.status  = ST_OK;
        if (op == OP_INSERT) begin
            if (model_size >= CAPACITY) begin
                ans.status = ST_FULL;
            end
            else begin
                model_size++;
                pos = model_size;
                model_heap[pos] = key;
                while (pos > 1) begin
                    if (!(model_heap[pos / 2] < model_heap[pos]))
                        break;
                    tmp = model_heap[pos / 2];
                    model_heap[pos / 2] = model_heap[pos];
                    model_heap[pos] = tmp;
                    pos = pos / 2;
                end
            end
        end
        else if (model_size == 0) begin
            ans.status = ST_EMPTY;
        end
        else begin
            ans.removed = model_heap[1];
            model_heap[1] = model_heap[model_size];
            model_size--;
            pos = 1;
            while (2 * pos <= model_size) begin
                kid = 2 * pos;
                if (kid + 1 <= model_size && model_heap[kid] < model_heap[kid + 1])
                    kid++;
                if (!(model_heap[pos] < model_heap[kid]))
                    break;
                tmp = model_heap[pos];
                model_heap[pos] = model_heap[kid];
                model_heap[kid] = tmp;
                pos = kid;
            end
        end
        ans.held = model_size[COUNT_W-1:0];
        return ans;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] key;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: key = $urandom;
            5, 6:          key = $signed($urandom_range(0, 16)) - 8;
            7:             key = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            8:             key = 32'sh7fffffff - $signed($urandom_range(0, 3));
            default:       key = 32'sh80000000 + $signed($urandom_range(0, 3));
        endcase
        return key;
    endfunction

    function automatic int pick_gap();
        int roll;
        if ($urandom_range(0, 39) == 0)
            steady = ~steady;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // start stays high after acceptance; it drops only when a gap follows or in drain()
    task automatic send_word(input logic op, input logic signed [KEY_W-1:0] key);
        int           gap;
        heap_answer_t ans;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        operation <= op;
        value     <= key;
        do @(posedge clk); while (busy);
        ans = heap_apply(op, key);
        pending_answers.push_back(ans);
        if (op == OP_INSERT)
            inserts_sent++;
        else
            removes_sent++;
        if (ans.status == ST_EMPTY)
            empty_removes++;
        if (ans.status == ST_FULL)
            full_inserts++;
        if (model_size > peak_size)
            peak_size = model_size;
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        send_word(OP_REMOVE, '0);
        send_word(OP_INSERT, 32'sd0);
        send_word(OP_INSERT, 32'sh7fffffff);
        send_word(OP_INSERT, 32'sh80000000);
        send_word(OP_INSERT, -32'sd1);
        send_word(OP_INSERT, 32'sd1);
        send_word(OP_INSERT, 32'sh55555555);
        send_word(OP_INSERT, 32'shaaaaaaaa);
        send_word(OP_INSERT, 32'sd5);
        send_word(OP_INSERT, 32'sd5);
        send_word(OP_INSERT, 32'sd5);
        send_word(OP_REMOVE, 32'sh7fffffff);
        repeat (10) send_word(OP_REMOVE, '0);
        send_word(OP_REMOVE, -32'sd1);
    endtask

    task automatic test_random_mix(input int n);
        int insert_pct;
        insert_pct = 50;
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0)
                insert_pct = $urandom_range(20, 80);
            if ($urandom_range(0, 99) < insert_pct)
                send_word(OP_INSERT, pick_key());
            else
                send_word(OP_REMOVE, $urandom);
        end
    endtask

    task automatic test_fill_drain();
        while (model_size < CAPACITY)
            send_word(OP_INSERT, pick_key());
        repeat (4) send_word(OP_INSERT, pick_key());
        while (model_size > 0)
            send_word(OP_REMOVE, $urandom);
        repeat (2) send_word(OP_REMOVE, $urandom);
    endtask

    task automatic test_near_full(input int n);
        while (model_size < CAPACITY - 6)
            send_word(OP_INSERT, pick_key());
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0)
                send_word(OP_INSERT, pick_key());
            else
                send_word(OP_REMOVE, $urandom);
        end
    endtask

    always @(posedge clk) begin
        heap_answer_t want;
        if (rst_n && done === 1'b1) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches < 50)
                    $display("%0t: result word with nothing expected: removed %0d status %0d count %0d",
                             $time, removed_value, status, count);
            end
            else begin
                want = pending_answers.pop_front();
                if (removed_value !== want.removed) begin
                    mismatches++;
                    if (mismatches < 50)
                        $display("%0t: removed_value expected %0d actual %0d",
                                 $time, want.removed, removed_value);
                end
                if (status !== want.status) begin
                    mismatches++;
                    if (mismatches < 50)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                end
                if (count !== want.held) begin
                    mismatches++;
                    if (mismatches < 50)
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.held, count);
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        drain();
        test_random_mix(500);
        drain();
        test_fill_drain();
        drain();
        test_near_full(250);
        drain();
        $display("covered %0d inserts and %0d removes, peak occupancy %0d of %0d",
                 inserts_sent, removes_sent, peak_size, CAPACITY);
        $display("including %0d removes on an empty heap and %0d inserts on a full heap",
                 empty_removes, full_inserts);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5000000;
        $display("%0t: timeout, %0d words still outstanding", $time, pending_answers.size());
        $display("end of test: mismatches");
        $finish;
    end
endmodule

### files.f
sv/mhpq_pkg.sv
sv/mhpq_ram.sv
sv/mhpq_cmp.sv
sv/max_heap_priority_queue_unit.sv
bench/testbench.sv
